### hdl/apw_pkg.sv
// ----------------------------------------------------------------------------
// apw_pkg: shared types and constants of the averaged knob LED window
// Sample and slot types, configuration register codes and reset values.
// ----------------------------------------------------------------------------
package apw_pkg;

  // Offset minus raw reading lies in -1023..255
  localparam int SAMP_W   = 11;
  localparam int RAW_W    = 10;
  localparam int OFS_W    = 8;
  localparam int LEN_W    = 11;
  localparam int LED_W    = 10;
  localparam int BRI_W    = 8;
  // Magnitude of any average fits this many bits
  localparam int QUO_W    = 10;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] STRIP_RST  = 11'd50;
  localparam logic [OFS_W-1:0] BRIGHT_RST = 8'd252;
  localparam logic [OFS_W-1:0] RANGE_RST  = 8'd112;
  localparam logic [OFS_W-1:0] PLACE_RST  = 8'd79;

  typedef logic signed [SAMP_W-1:0] samp_t;

  // One history slot: a sample of each knob
  typedef struct packed {
    samp_t bright;
    samp_t width;
    samp_t place;
  } slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIP_LENGTH    = 2'd0,
    REG_BRIGHT_OFFSET   = 2'd1,
    REG_RANGE_OFFSET    = 2'd2,
    REG_POSITION_OFFSET = 2'd3
  } cfg_reg_t;

endpackage

### hdl/apw_cell.sv
// ----------------------------------------------------------------------------
// apw_cell: one slot of the sample history line
// Holds one slot and hands it to the next cell on every accepted beat.
// ----------------------------------------------------------------------------
module apw_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  apw_pkg::slot_t slot_in,
  output apw_pkg::slot_t slot_out
);
  import apw_pkg::*;

  slot_t slot_r;

  // History starts at zero; the zeros count in the average
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (shift_en) begin
      slot_r <= slot_in;
    end
  end

  assign slot_out = slot_r;

endmodule

### hdl/apw_div.sv
// ----------------------------------------------------------------------------
// apw_div: running total divided by the window depth
// Reciprocal multiply on the magnitude, truncation toward zero.
// ----------------------------------------------------------------------------
module apw_div #(
  parameter int AVG_DEPTH = 30,
  parameter int TOT_W     = 16
) (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [TOT_W-1:0]  total,
  output apw_pkg::samp_t           avg
);
  import apw_pkg::*;

  localparam int MAG_W  = TOT_W - 1;
  localparam int SH     = MAG_W + $clog2(AVG_DEPTH);
  localparam int M_W    = SH + 1;
  localparam int PROD_W = MAG_W + M_W;
  // ceil(2^SH / depth): exact for every MAG_W-bit numerator
  localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << SH) + AVG_DEPTH - 1) / AVG_DEPTH);

  logic [TOT_W-1:0]  mag_full;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod_nxt, prod_r;
  logic              neg_r;
  logic [QUO_W-1:0]  quo;
  samp_t             quo_s;

  assign mag_full = (total < 0) ? TOT_W'(-total) : TOT_W'(total);
  assign mag      = mag_full[MAG_W-1:0];
  assign prod_nxt = PROD_W'(mag) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      neg_r  <= (total < 0);
    end
  end

  assign quo   = prod_r[SH +: QUO_W];
  assign quo_s = $signed({1'b0, quo});
  assign avg   = neg_r ? -quo_s : quo_s;

endmodule

### hdl/averaged_pot_led_window.sv
// ----------------------------------------------------------------------------
// averaged_pot_led_window: boxcar-averaged knob readings to an LED window
// Averages brightness, half-width and position over a sliding window and
// turns them into a brightness and the first and last lit LED.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Beat contents
//  in_      sink       in_valid / in_stall   bright, width, place samples
//  out_     source     out_valid / out_stall brightness, window start/end
//  cfg_     sink       cfg_wr_en             register index and data
//
//  One beat per cycle, sustained while out_stall stays low; the running-total
//  update at the head of the pipe is the only loop.
//  A result moves from the running totals through the divider products and
//  the clamp registers into the output register, and leaves once out_stall is low.
//  Reset clears the history line, the totals and all valid flags at once.
//  Each stage moves when the one after it is empty or moving, so bubbles
//  close up behind a stalled output; in_stall rises only once all are full.
//
module averaged_pot_led_window #(
  parameter int AVG_DEPTH = 30,
  parameter int MAX_LEDS  = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [apw_pkg::RAW_W-1:0]         in_bright_sample,
  input  logic [apw_pkg::RAW_W-1:0]         in_width_sample,
  input  logic [apw_pkg::RAW_W-1:0]         in_place_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [apw_pkg::BRI_W-1:0]         out_brightness,
  output logic [apw_pkg::LED_W-1:0]         out_window_start,
  output logic [apw_pkg::LED_W-1:0]         out_window_end,
  input  logic                              cfg_wr_en,
  input  logic [apw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apw_pkg::CFG_W-1:0]         cfg_wdata
);
  import apw_pkg::*;

  // Totals must hold depth * 1023 in magnitude, plus the sign
  localparam int TOT_W = $clog2(AVG_DEPTH * 1024) + 1;
  // Strip length is capped so the indices fit the output fields
  localparam int LIM_INT = (MAX_LEDS < 1024) ? MAX_LEDS : 1024;
  localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(LIM_INT);
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0] strip_length_r;
  logic [OFS_W-1:0] bright_offset_r, range_offset_r, position_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_length_r    <= STRIP_RST;
      bright_offset_r   <= BRIGHT_RST;
      range_offset_r    <= RANGE_RST;
      position_offset_r <= PLACE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_STRIP_LENGTH:    strip_length_r    <= cfg_wdata;
        REG_BRIGHT_OFFSET:   bright_offset_r   <= cfg_wdata[OFS_W-1:0];
        REG_RANGE_OFFSET:    range_offset_r    <= cfg_wdata[OFS_W-1:0];
        REG_POSITION_OFFSET: position_offset_r <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Last usable LED index, from the clamped strip length
  logic [LEN_W-1:0] len_eff;
  logic [LED_W-1:0] last_led;

  always_comb begin
    len_eff = strip_length_r;
    if (strip_length_r < LEN_MIN) len_eff = LEN_MIN;
    if (strip_length_r > LEN_LIM) len_eff = LEN_LIM;
  end
  assign last_led = LED_W'(len_eff - LEN_W'(1));

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when the next one is empty or advancing
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy_out, rdy3, rdy2, rdy1, in_accept;

  assign rdy_out   = !out_valid_r || !out_stall;
  assign rdy3      = !v3_r || rdy_out;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_stall  = !rdy1;
  assign in_accept = in_valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_accept;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: offset minus reading, history line shift, running totals
  // --------------------------------------------------------------------------
  slot_t new_slot;
  slot_t chain [0:AVG_DEPTH];

  assign new_slot.bright = $signed({3'b000, bright_offset_r})
                         - $signed({1'b0, in_bright_sample});
  assign new_slot.width  = $signed({3'b000, range_offset_r})
                         - $signed({1'b0, in_width_sample});
  assign new_slot.place  = $signed({3'b000, position_offset_r})
                         - $signed({1'b0, in_place_sample});
  assign chain[0] = new_slot;

  // The last cell holds the sample that drops out of the window
  for (genvar k = 0; k < AVG_DEPTH; k++) begin : g_hist
    apw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_accept),
      .slot_in  (chain[k]),
      .slot_out (chain[k+1])
    );
  end

  logic signed [TOT_W-1:0] bright_total_r, width_total_r, place_total_r;
  logic signed [TOT_W-1:0] bright_total_nxt, width_total_nxt, place_total_nxt;

  assign bright_total_nxt = bright_total_r + TOT_W'(new_slot.bright)
                          - TOT_W'(chain[AVG_DEPTH].bright);
  assign width_total_nxt  = width_total_r + TOT_W'(new_slot.width)
                          - TOT_W'(chain[AVG_DEPTH].width);
  assign place_total_nxt  = place_total_r + TOT_W'(new_slot.place)
                          - TOT_W'(chain[AVG_DEPTH].place);

  // Totals change only on an accepted beat, so they are stage 1's payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_total_r <= '0;
      width_total_r  <= '0;
      place_total_r  <= '0;
    end else if (in_accept) begin
      bright_total_r <= bright_total_nxt;
      width_total_r  <= width_total_nxt;
      place_total_r  <= place_total_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide each total by the depth (product registered inside)
  // --------------------------------------------------------------------------
  samp_t avg_bright, avg_width, avg_place;

  apw_div #(.AVG_DEPTH(AVG_DEPTH), .TOT_W(TOT_W)) u_div_bright (
    .clk (clk), .load (rdy2), .total (bright_total_r), .avg (avg_bright)
  );
  apw_div #(.AVG_DEPTH(AVG_DEPTH), .TOT_W(TOT_W)) u_div_width (
    .clk (clk), .load (rdy2), .total (width_total_r), .avg (avg_width)
  );
  apw_div #(.AVG_DEPTH(AVG_DEPTH), .TOT_W(TOT_W)) u_div_place (
    .clk (clk), .load (rdy2), .total (place_total_r), .avg (avg_place)
  );

  // --------------------------------------------------------------------------
  // Stage 3: clamp brightness at zero, half-width to at least one,
  // position onto the strip
  // --------------------------------------------------------------------------
  logic [BRI_W-1:0] bri_nxt, bri_r;
  logic [OFS_W-1:0] half_nxt, half_r;
  logic [LED_W-1:0] pos_nxt, pos_r;

  always_comb begin
    bri_nxt = (avg_bright < 0) ? '0 : avg_bright[BRI_W-1:0];
    half_nxt = (avg_width < 1) ? OFS_W'(1) : avg_width[OFS_W-1:0];
    if (avg_place < 0) begin
      pos_nxt = '0;
    end else if (avg_place > $signed({1'b0, last_led})) begin
      pos_nxt = last_led;
    end else begin
      pos_nxt = avg_place[LED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      bri_r  <= bri_nxt;
      half_r <= half_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: window edges, then widen a one-LED window into the output
  // register
  // --------------------------------------------------------------------------
  logic signed [LED_W:0] lo_diff;
  logic [LED_W:0]        hi_sum;
  logic [LED_W-1:0]      start_c, end_c, start_nxt, end_nxt;
  logic [BRI_W-1:0]      bri_out_r;
  logic [LED_W-1:0]      start_out_r, end_out_r;

  always_comb begin
    lo_diff = $signed({1'b0, pos_r}) - $signed({3'b000, half_r});
    hi_sum  = {1'b0, pos_r} + {3'b000, half_r};
    start_c = (lo_diff < 0) ? '0 : lo_diff[LED_W-1:0];
    end_c   = (hi_sum > {1'b0, last_led}) ? last_led : hi_sum[LED_W-1:0];
    start_nxt = start_c;
    end_nxt   = end_c;
    // Empty window: push the end right, or the start left at the strip head
    if (end_c <= start_c) begin
      if (start_c != '0) begin
        end_nxt = start_c + LED_W'(1);
      end else begin
        start_nxt = end_c - LED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      bri_out_r   <= bri_r;
      start_out_r <= start_nxt;
      end_out_r   <= end_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_brightness   = bri_out_r;
  assign out_window_start = start_out_r;
  assign out_window_end   = end_out_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted beat did not reach stage 1");

  a_half_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> half_r != '0)
    else $error("half-width reached zero");

  a_pos_on_strip: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> pos_r <= last_led)
    else $error("position beyond the strip");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_window_end > out_window_start)
    else $error("window end not past window start");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipe");

endmodule
